// ===== rtl/plgr_pkg.sv =====
//------------------------------------------------------------------------------
// plgr_pkg
// Shared types and constants of the per-channel linear gain ramp.
//------------------------------------------------------------------------------
package plgr_pkg;

   localparam int unsigned UnityGain = 65536;
   localparam int unsigned TimeShift = 28;
   localparam int unsigned SlopeScaleShift = 3;

   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [2:0] CSR_GAIN_MIN      = 3'd1;
   localparam logic [2:0] CSR_GAIN_MAX      = 3'd2;
   localparam logic [2:0] CSR_RAMP_MS       = 3'd3;
   localparam logic [2:0] CSR_FULL_RANGE    = 3'd4;
   localparam logic [2:0] CSR_RAMP_KIND     = 3'd5;
   localparam logic [2:0] CSR_RATE_INV      = 3'd6;

   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_MUTE   = 2'd1;
   localparam logic [1:0] MODE_UNMUTE = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   // divider request/response
   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [32:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/plgr_div.sv =====
//------------------------------------------------------------------------------
// plgr_div
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module plgr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  plgr_pkg::div_req_type req,
   output plgr_pkg::div_rsp_type rsp
);

   logic [32:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[32]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/per_channel_linear_gain_ramp.sv =====
//------------------------------------------------------------------------------
// per_channel_linear_gain_ramp
// Per-channel Q16.16 gain ramp with mute/unmute and linear or jump stepping.
//
// channel | direction | handshake
// req_*   | in        | req_valid / req_stall
// rsp_*   | out       | rsp_valid / rsp_stall
// csr_*   | in        | csr_write, no wait
//
// Set target/mute/unmute: the request passes S_SET and S_SDIV; with a nonzero ramp
// time S_SFIN waits for the bit-serial divider, with a zero ramp time it does not,
// and a jump returns to idle from S_SDIV. A repeated mute or unmute is dropped.
// Tick: S_TMUL and S_TRND for the ramp time, then S_CRD, S_CMUL and S_CUPD per
// channel stepping through one shared multiplier, S_PASS per channel for the
// passthrough check, then a load step and one beat per channel in S_EMIT; no new beat while busy.
// Reset is synchronous and clears all gain state. A stalled result holds.
//------------------------------------------------------------------------------
module per_channel_linear_gain_ramp #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_channel,
   input  logic [30:0]        req_target_gain,
   input  logic               req_constant_rate,
   input  logic [15:0]        req_frames,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_channel_res,
   output logic signed [31:0] rsp_gain,
   output logic               rsp_ramp_done,
   output logic               rsp_unity_passthrough,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_data
);

   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NW = $clog2(MAX_CHANNELS + 1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SET   = 11'b00000000010,
      S_SDIV  = 11'b00000000100,
      S_SFIN  = 11'b00000001000,
      S_TMUL  = 11'b00000010000,
      S_TRND  = 11'b00000100000,
      S_CRD   = 11'b00001000000,
      S_CMUL  = 11'b00010000000,
      S_CUPD  = 11'b00100000000,
      S_PASS  = 11'b01000000000,
      S_EMIT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]  cnt_cfg_ff;
   logic [30:0] gmin_ff, gmax_ff, frange_ff, rinv_ff;
   logic [15:0] rms_ff;
   logic        kind_ff;

   logic signed [31:0] cur_ff [MAX_CHANNELS];
   logic signed [31:0] goal_ff [MAX_CHANNELS];
   logic signed [31:0] start_ff [MAX_CHANNELS];
   logic signed [31:0] slope_ff [MAX_CHANNELS];
   logic signed [31:0] saved_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] muted_ff;
   logic [31:0] elapsed_ff;
   logic        fin_ff, pass_ff;

   logic [1:0]  mode_ff;
   logic [CW-1:0] ch_ff;
   logic [30:0] req_gain_ff;
   logic        crate_ff;
   logic [15:0] frames_ff;
   logic [NW-1:0] n_ff;
   logic [NW-1:0] idx_ff;
   logic [31:0] t_ff;
   logic signed [63:0] prod_ff;
   logic [32:0] mag_ff;
   logic        neg_ff;

   logic [2:0]  o_ch_ff;
   logic signed [31:0] o_gain_ff;
   logic        o_valid_ff;

   plgr_pkg::div_req_type dreq;
   plgr_pkg::div_rsp_type drsp;

   plgr_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // drop a repeated mute or unmute
   wire skip_req = (req_mode == plgr_pkg::MODE_MUTE && muted_ff[CW'(req_channel)]) ||
                   (req_mode == plgr_pkg::MODE_UNMUTE && !muted_ff[CW'(req_channel)]);

   // shared multiplier: elapsed*rate or t*slope
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   wire [CW-1:0] ci = idx_ff[CW-1:0];
   always_comb begin
      if (state_ff == S_TMUL) begin
         mul_a = $signed({1'b0, elapsed_ff});
         mul_b = $signed({2'b0, rinv_ff});
      end else begin
         mul_a = $signed({1'b0, t_ff});
         mul_b = $signed({slope_ff[ci][31], slope_ff[ci]});
      end
      mul_p = mul_a * mul_b;
   end

   // set-target datapath (combinational pieces in S_SET)
   logic [30:0] clamp_v;
   logic signed [33:0] delta;
   logic [32:0] mag;
   always_comb begin
      clamp_v = req_gain_ff;
      if (clamp_v < gmin_ff) clamp_v = gmin_ff;
      if (clamp_v > gmax_ff) clamp_v = gmax_ff;
      delta = $signed({3'b0, clamp_v}) - $signed({{2{cur_ff[ch_ff][31]}}, cur_ff[ch_ff]});
      mag = delta[33] ? 33'(-delta) : delta[32:0];
   end

   // slope finish
   logic [32:0] c_base;
   logic [33:0] c_rnd;
   logic [31:0] c_scl;
   logic [31:0] c_pos;
   logic signed [31:0] c_fin;
   always_comb begin
      c_rnd = {1'b0, drsp.quotient} + 34'd1;
      c_base = (rms_ff != 16'd0) ? c_rnd[33:1] : mag_ff;
      c_scl = 32'((34'(c_base >> (plgr_pkg::SlopeScaleShift - 1)) + 34'd1) >> 1);
      c_pos = (c_scl == 32'd0) ? 32'd1 : c_scl;
      // magnitude fits in 31 bits here
      c_fin = neg_ff ? -$signed(c_pos) : $signed(c_pos);
   end

   // tick step
   logic signed [64:0] nv;
   logic signed [31:0] cur_c, goal_c, nv_sat;
   logic               step_unfin;
   always_comb begin
      cur_c  = cur_ff[ci];
      goal_c = goal_ff[ci];
      if (kind_ff)
         nv = 65'($signed(start_ff[ci])) + 65'(prod_ff);
      else
         nv = 65'(goal_c);
      step_unfin = 1'b0;
      if (cur_c < goal_c) begin
         if (nv < 65'(goal_c)) step_unfin = 1'b1;
         else nv = 65'(goal_c);
      end else begin
         if (nv > 65'(goal_c)) step_unfin = 1'b1;
         else nv = 65'(goal_c);
      end
      if (nv > 65'sh7FFFFFFF) nv_sat = 32'sh7FFFFFFF;
      else if (nv < -65'sh80000000) nv_sat = 32'sh80000000;
      else nv_sat = nv[31:0];
   end

   logic [32:0] el_sum;
   logic [36:0] t_rnd;
   assign el_sum = {1'b0, elapsed_ff} + {17'b0, frames_ff};
   assign t_rnd = (37'(prod_ff[63:plgr_pkg::TimeShift-1]) + 37'd1) >> 1;

   wire [NW-1:0] last_idx = n_ff - NW'(1);

   always_comb begin
      state_in = state_ff;
      dreq.start = 1'b0;
      dreq.dividend = (crate_ff && frange_ff != 31'd0) ? {1'b0, frange_ff, 1'b0}
                                                       : {mag_ff[31:0], 1'b0};
      dreq.divisor = rms_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if (req_mode == plgr_pkg::MODE_TICK) state_in = S_TMUL;
            else if (32'(req_channel) < MAX_CHANNELS && !skip_req) state_in = S_SET;
         end
         S_SET:  state_in = S_SDIV;
         S_SDIV: begin
            if (!kind_ff) state_in = S_IDLE;
            else if (rms_ff == 16'd0) state_in = S_SFIN;
            else begin
               dreq.start = 1'b1;
               state_in = S_SFIN;
            end
         end
         S_SFIN: if (rms_ff == 16'd0 || drsp.done) state_in = S_IDLE;
         S_TMUL: state_in = S_TRND;
         S_TRND: state_in = (n_ff == '0) ? S_PASS : S_CRD;
         S_CRD:  state_in = S_CMUL;
         S_CMUL: state_in = S_CUPD;
         S_CUPD: state_in = (idx_ff == last_idx) ? S_PASS : S_CRD;
         S_PASS: state_in = (idx_ff == last_idx || n_ff == '0) ?
                            ((n_ff == '0) ? S_IDLE : S_EMIT) : S_PASS;
         S_EMIT: if (!o_valid_ff || !rsp_stall)
                    if (idx_ff == last_idx && o_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_cfg_ff <= 4'd2;
         gmin_ff    <= '0;
         gmax_ff    <= 31'd65536;
         rms_ff     <= '0;
         frange_ff  <= '0;
         kind_ff    <= 1'b1;
         rinv_ff    <= 31'd44739242;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            cur_ff[i]   <= '0;
            goal_ff[i]  <= '0;
            start_ff[i] <= '0;
            slope_ff[i] <= '0;
            saved_ff[i] <= '0;
         end
         muted_ff   <= '0;
         elapsed_ff <= '0;
         fin_ff     <= 1'b1;
         pass_ff    <= 1'b0;
         o_valid_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               plgr_pkg::CSR_CHANNEL_COUNT: cnt_cfg_ff <= csr_data[3:0];
               plgr_pkg::CSR_GAIN_MIN:      gmin_ff <= csr_data;
               plgr_pkg::CSR_GAIN_MAX:      gmax_ff <= csr_data;
               plgr_pkg::CSR_RAMP_MS:       rms_ff <= csr_data[15:0];
               plgr_pkg::CSR_FULL_RANGE:    frange_ff <= csr_data;
               plgr_pkg::CSR_RAMP_KIND:     kind_ff <= csr_data[0];
               plgr_pkg::CSR_RATE_INV:      rinv_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (accept) begin
               mode_ff     <= req_mode;
               ch_ff       <= CW'(req_channel);
               req_gain_ff <= (req_mode == plgr_pkg::MODE_MUTE) ? '0 :
                              (req_mode == plgr_pkg::MODE_UNMUTE) ?
                              saved_ff[CW'(req_channel)][30:0] : req_target_gain;
               crate_ff    <= (req_mode == plgr_pkg::MODE_MUTE ||
                               req_mode == plgr_pkg::MODE_UNMUTE) ? 1'b1 : req_constant_rate;
               frames_ff   <= req_frames;
               n_ff        <= (32'(cnt_cfg_ff) > MAX_CHANNELS)
                              ? NW'(MAX_CHANNELS) : NW'(cnt_cfg_ff);
               idx_ff      <= '0;
            end
            S_SET: begin
               if (mode_ff == plgr_pkg::MODE_MUTE) begin
                  saved_ff[ch_ff] <= goal_ff[ch_ff];
                  muted_ff[ch_ff] <= 1'b1;
               end else if (mode_ff == plgr_pkg::MODE_UNMUTE) begin
                  muted_ff[ch_ff] <= 1'b0;
               end
               goal_ff[ch_ff]  <= $signed({1'b0, clamp_v});
               start_ff[ch_ff] <= cur_ff[ch_ff];
               elapsed_ff      <= '0;
               mag_ff          <= mag;
               neg_ff          <= delta[33];
            end
            S_SFIN: if (rms_ff == 16'd0 || drsp.done) slope_ff[ch_ff] <= c_fin;
            S_TMUL: begin
               prod_ff <= 64'(mul_p);
               fin_ff  <= 1'b1;
            end
            S_TRND: t_ff <= (t_rnd > 37'h7FFFFFFF) ? 32'h7FFFFFFF : t_rnd[31:0];
            S_CMUL: prod_ff <= 64'(mul_p);
            S_CUPD: begin
               if (cur_c != goal_c) begin
                  cur_ff[ci] <= nv_sat;
                  if (step_unfin) fin_ff <= 1'b0;
               end
               idx_ff <= (idx_ff == last_idx) ? '0 : idx_ff + NW'(1);
               if (idx_ff == last_idx) pass_ff <= 1'b1;
            end
            S_PASS: begin
               if (n_ff == '0) begin
                  pass_ff <= fin_ff;
                  elapsed_ff <= el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
               end else begin
                  if (cur_ff[ci] != 32'(plgr_pkg::UnityGain) || !fin_ff)
                     pass_ff <= 1'b0;
                  idx_ff <= (idx_ff == last_idx) ? '0 : idx_ff + NW'(1);
               end
            end
            S_EMIT: if (!o_valid_ff || !rsp_stall) begin
               if (o_valid_ff && idx_ff == last_idx) begin
                  o_valid_ff <= 1'b0;
                  elapsed_ff <= el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
                  idx_ff <= '0;
               end else begin
                  o_valid_ff <= 1'b1;
                  if (o_valid_ff) begin
                     idx_ff    <= idx_ff + NW'(1);
                     o_ch_ff   <= 3'(idx_ff + NW'(1));
                     o_gain_ff <= cur_ff[CW'(idx_ff + NW'(1))];
                  end else begin
                     o_ch_ff   <= 3'(idx_ff);
                     o_gain_ff <= cur_ff[ci];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid             = o_valid_ff;
   assign rsp_channel_res       = o_ch_ff;
   assign rsp_gain              = o_gain_ff;
   assign rsp_ramp_done         = fin_ff;
   assign rsp_unity_passthrough = pass_ff;
   assign rsp_last              = (NW'(o_ch_ff) == last_idx);

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("accepting while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_gain)))
      else $error("result dropped under stall");
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_EMIT))
      else $error("result outside emit");

endmodule
